/* hw/rtl/tga_rle_pixel_decoder_defines.svh */
// Assertion macros used by the checker file of the pixel decoder.
`ifndef TGA_RLE_PIXEL_DECODER_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TRPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pixel decoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TRPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pixel decoder check failed");

`endif

/* hw/rtl/trpd_pkg.sv */
// ----------------------------------------------------------------------------
// trpd_pkg
// Shared type, register indexes and helper function of the pixel decoder.
// ----------------------------------------------------------------------------
package trpd_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_COMPRESSED   = 2'd0;
  localparam logic [1:0] REG_PIXEL_BYTES  = 2'd1;
  localparam logic [1:0] REG_CONVERT_MODE = 2'd2;
  localparam logic [1:0] REG_ALPHA_ENABLE = 2'd3;

  // Pixel conversion modes.
  localparam logic [1:0] CONV_PASS   = 2'd0;
  localparam logic [1:0] CONV_SWAP   = 2'd1;
  localparam logic [1:0] CONV_EXPAND = 2'd2;

  localparam logic [7:0] RUN_FLAG = 8'h80;

  typedef struct packed {
    logic [1:0] convert_mode;
    logic       alpha_enable;
  } conv_cfg_t;

  // Widen a 5-bit channel to 8 bits by replicating its top bits.
  function automatic logic [7:0] widen5(input logic [4:0] v);
    widen5 = {v, v[4:2]};
  endfunction

endpackage

/* hw/rtl/trpd_convert.sv */
// ----------------------------------------------------------------------------
// trpd_convert
// Converts one gathered pixel: passthrough, byte 0/2 swap or 555 expansion.
// ----------------------------------------------------------------------------
module trpd_convert (
  input  logic [31:0]         raw_i,
  input  logic [2:0]          nbytes_i,
  input  trpd_pkg::conv_cfg_t cfg_i,
  output logic [31:0]         value_o,
  output logic [2:0]          width_o
);

  logic [7:0] lo;
  logic [7:0] hi;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  assign lo    = raw_i[7:0];
  assign hi    = raw_i[15:8];
  assign red   = trpd_pkg::widen5(hi[6:2]);
  assign green = {hi[1:0], lo[7:5], hi[1:0], lo[7]};
  assign blue  = trpd_pkg::widen5(lo[4:0]);
  assign alpha = hi[7] ? 8'hff : 8'h00;

  always_comb begin
    value_o = raw_i;
    width_o = nbytes_i;
    case (cfg_i.convert_mode)
      trpd_pkg::CONV_EXPAND: begin
        if (cfg_i.alpha_enable) begin
          value_o = {alpha, blue, green, red};
          width_o = 3'd4;
        end else begin
          value_o = {8'h00, blue, green, red};
          width_o = 3'd3;
        end
      end
      trpd_pkg::CONV_SWAP: begin
        // Only a pixel of three or more bytes has a third byte to swap.
        if (nbytes_i >= 3'd3) begin
          value_o = {raw_i[31:24], raw_i[7:0], raw_i[15:8], raw_i[23:16]};
        end
      end
      default: begin
        value_o = raw_i;
        width_o = nbytes_i;
      end
    endcase
  end

endmodule

/* hw/rtl/tga_rle_pixel_decoder.sv */
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Run-length packet decoder for image payload bytes with pixel conversion.
// ----------------------------------------------------------------------------
// The input channel carries one payload word per transfer: a data byte and a
// restart flag that clears the packet state before that byte is used. A word
// moves when in_valid_i is high and in_stall_o is low. The output channel
// carries one converted pixel with its width in bytes and its repeat count;
// it moves when out_valid_o is high and out_stall_i is low. Header bytes and
// bytes that do not complete a pixel give no output word.
// Each byte is decoded in the cycle it is accepted and its pixel, if any, is
// shown from the output register on the next cycle, one word per cycle while
// out_stall_i is low. The single output register sets that rate: a new byte
// is taken whenever the register is empty or is drained in the same cycle, so
// in_stall_o follows out_stall_i only while a pixel waits. Reset leaves the
// output empty, the packet state expecting a header, and the registers at raw
// mode, three bytes per pixel, passthrough, no alpha. Configuration writes
// through cfg_we_i must be made only while the block idles; it is unchecked.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [2:0]  cfg_data_i,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        restart_i,
  // Output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pixel_value_o,
  output logic [2:0]  pixel_width_o,
  output logic [7:0]  run_length_o
);

  // Configuration registers.
  logic       compressed_q;
  logic [2:0] pixel_bytes_q;
  logic [1:0] convert_mode_q;
  logic       alpha_enable_q;

  // Packet state.
  logic        expect_hdr_q, expect_hdr_d;
  logic [7:0]  literal_left_q, literal_left_d;
  logic [7:0]  run_pending_q, run_pending_d;
  logic [1:0]  byte_pos_q, byte_pos_d;
  logic [31:0] gather_q, gather_d;

  // Output register.
  logic        out_valid_q;
  logic [31:0] pixel_value_q;
  logic [2:0]  pixel_width_q;
  logic [7:0]  run_length_q;

  logic        out_ready;
  logic        in_fire;
  logic        pix_done;
  logic [7:0]  count;
  logic [2:0]  nbytes;
  logic [31:0] gather_new;
  logic [31:0] conv_value;
  logic [2:0]  conv_width;

  // State as seen by this byte, after an optional restart.
  logic        eh;
  logic [7:0]  lit;
  logic [7:0]  run;
  logic [1:0]  pos;
  logic [31:0] gat;
  logic [7:0]  lit_dec;

  trpd_pkg::conv_cfg_t conv_cfg;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !out_ready;
  assign in_fire    = in_valid_i && out_ready;

  // Out-of-range byte counts are clamped to the nearest legal value.
  always_comb begin
    if (pixel_bytes_q == 3'd0) begin
      nbytes = 3'd1;
    end else if (pixel_bytes_q > 3'd4) begin
      nbytes = 3'd4;
    end else begin
      nbytes = pixel_bytes_q;
    end
  end

  always_comb begin
    eh  = restart_i ? 1'b1 : expect_hdr_q;
    lit = restart_i ? 8'd0 : literal_left_q;
    run = restart_i ? 8'd0 : run_pending_q;
    pos = restart_i ? 2'd0 : byte_pos_q;
    gat = restart_i ? 32'd0 : gather_q;

    gather_new = gat | ({24'd0, data_byte_i} << {pos, 3'b000});
    lit_dec    = (lit != 8'd0) ? lit - 8'd1 : lit;

    expect_hdr_d   = eh;
    literal_left_d = lit;
    run_pending_d  = run;
    byte_pos_d     = pos;
    gather_d       = gat;
    pix_done       = 1'b0;
    count          = 8'd1;

    if (compressed_q && eh) begin
      // Header byte: the top bit selects a run packet or a literal packet.
      if (data_byte_i >= trpd_pkg::RUN_FLAG) begin
        run_pending_d  = data_byte_i - 8'd127;
        literal_left_d = 8'd0;
      end else begin
        literal_left_d = data_byte_i + 8'd1;
        run_pending_d  = 8'd0;
      end
      expect_hdr_d = 1'b0;
      byte_pos_d   = 2'd0;
      gather_d     = 32'd0;
    end else if (({1'b0, pos} + 3'd1) < nbytes) begin
      byte_pos_d = pos + 2'd1;
      gather_d   = gather_new;
    end else begin
      pix_done   = 1'b1;
      byte_pos_d = 2'd0;
      gather_d   = 32'd0;
      if (compressed_q) begin
        if (run != 8'd0) begin
          count         = run;
          run_pending_d = 8'd0;
          expect_hdr_d  = 1'b1;
        end else begin
          literal_left_d = lit_dec;
          if (lit_dec == 8'd0) begin
            expect_hdr_d = 1'b1;
          end
        end
      end
    end
  end

  assign conv_cfg.convert_mode = convert_mode_q;
  assign conv_cfg.alpha_enable = alpha_enable_q;

  trpd_convert u_convert (
    .raw_i    (gather_new),
    .nbytes_i (nbytes),
    .cfg_i    (conv_cfg),
    .value_o  (conv_value),
    .width_o  (conv_width)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compressed_q   <= 1'b0;
      pixel_bytes_q  <= 3'd3;
      convert_mode_q <= trpd_pkg::CONV_PASS;
      alpha_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        trpd_pkg::REG_COMPRESSED:   compressed_q   <= cfg_data_i[0];
        trpd_pkg::REG_PIXEL_BYTES:  pixel_bytes_q  <= cfg_data_i;
        trpd_pkg::REG_CONVERT_MODE: convert_mode_q <= cfg_data_i[1:0];
        trpd_pkg::REG_ALPHA_ENABLE: alpha_enable_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_hdr_q   <= 1'b1;
      literal_left_q <= 8'd0;
      run_pending_q  <= 8'd0;
      byte_pos_q     <= 2'd0;
      gather_q       <= 32'd0;
    end else if (in_fire) begin
      expect_hdr_q   <= expect_hdr_d;
      literal_left_q <= literal_left_d;
      run_pending_q  <= run_pending_d;
      byte_pos_q     <= byte_pos_d;
      gather_q       <= gather_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_fire && pix_done;
    end
  end

  // The payload loads only when a pixel completes into a free register.
  always_ff @(posedge clk_i) begin
    if (in_fire && pix_done) begin
      pixel_value_q <= conv_value;
      pixel_width_q <= conv_width;
      run_length_q  <= count;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = pixel_value_q;
  assign pixel_width_o = pixel_width_q;
  assign run_length_o  = run_length_q;

endmodule

/* hw/rtl/trpd_checker.sv */
// ----------------------------------------------------------------------------
// trpd_checker
// Port-level checks of the pixel decoder, bound to its top level.
// ----------------------------------------------------------------------------
`include "tga_rle_pixel_decoder_defines.svh"

module trpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] pixel_value_o,
  input logic [2:0]  pixel_width_o,
  input logic [7:0]  run_length_o
);

  logic out_held;
  logic out_legal;

  assign out_held  = out_valid_o && out_stall_i;
  assign out_legal = run_length_o != 8'd0 && pixel_width_o != 3'd0 &&
                     pixel_width_o <= 3'd4;

  // A stalled word stays offered with its value and run length unchanged.
  `TRPD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o)
  `TRPD_ASSERT_NEXT(a_value_stable, clk_i, rst_ni, out_held, $stable(pixel_value_o))
  `TRPD_ASSERT_NEXT(a_run_stable, clk_i, rst_ni, out_held, $stable(run_length_o))

  // The decoder only pushes back while a finished pixel is waiting.
  `TRPD_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_stall_o, out_held)

  // Every pixel carries a legal width and at least one copy.
  `TRPD_ASSERT_NOW(a_out_legal, clk_i, rst_ni, out_valid_o, out_legal)

endmodule

bind tga_rle_pixel_decoder trpd_checker u_trpd_checker (.*);

/* sim/tga_rle_pixel_decoder_tb.sv */
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_tb
// Self-checking testbench for the run-length pixel decoder. A queue-fed driver
// sends payload bytes, a per-byte predictor works out each pixel word, and
// a monitor compares every output word with the oldest predicted one.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Convert mode 3 has no name in the package; the block treats it as
  // passthrough.
  localparam logic [1:0] CONV_SPARE = 2'd3;
  // Cycles without any transfer on either channel before the run is abandoned.
  localparam int unsigned STALL_LIMIT = 2000;
  // Items per random phase, split in two halves, with a full drain between them on every other phase.
  localparam int unsigned PHASE_ITEMS = 190;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_e;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
  } payload_t;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  width;
    logic [7:0]  count;
  } pixel_t;

  typedef struct packed {
    logic       comp;
    logic [2:0] nbytes;
    logic [1:0] mode;
    logic       alpha;
  } setting_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = trpd_pkg::REG_COMPRESSED;
  logic [2:0]  cfg_data_i = 3'd0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'd0;
  logic        restart_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] pixel_value_o;
  logic [2:0]  pixel_width_o;
  logic [7:0]  run_length_o;

  tga_rle_pixel_decoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_value_o(pixel_value_o),
    .pixel_width_o(pixel_width_o),
    .run_length_o (run_length_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bytes waiting to be driven and pixel words still owed by the block.
  payload_t payload_q[$];
  pixel_t   pixel_due_q[$];
  idle_e    idle_mode = IDLE_NONE;
  int unsigned pushed = 0;
  int unsigned mismatches = 0;

  // Mirror of the configuration registers, reset values included.
  logic       cfg_comp = 1'b0;
  logic [2:0] cfg_nbytes = 3'd3;
  logic [1:0] cfg_mode = trpd_pkg::CONV_PASS;
  logic       cfg_alpha = 1'b0;

  // Mirror of the packet state. A restart or reset leaves the decoder
  // waiting for a header with both counters and the partial pixel cleared.
  logic        want_header = 1'b1;
  logic [7:0]  literal_left = 8'd0;
  logic [7:0]  run_left = 8'd0;
  logic [1:0]  byte_pos = 2'd0;
  logic [31:0] gather = 32'd0;

  // The pixel byte count register saturates: zero acts as one byte and any
  // value above four as four bytes.
  function automatic int unsigned stored_bytes();
    if (cfg_nbytes == 3'd0) return 1;
    if (cfg_nbytes > 3'd4) return 4;
    return cfg_nbytes;
  endfunction

  // Stretches a channel held in the top bits of a byte by copying its top
  // bits into the empty low bits.
  function automatic logic [7:0] fill_low(input logic [7:0] t);
    return t + (t >> 5);
  endfunction

  function automatic void push_byte(input logic [7:0] data, input logic restart);
    payload_q.push_back('{data: data, restart: restart});
    pushed++;
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // Advances the packet state by one accepted byte and queues the pixel word
  // that the byte completes, if it completes one.
  function automatic void decode_byte(input logic [7:0] b, input logic restart);
    int unsigned nb;
    pixel_t px;
    logic [31:0] raw;
    logic [7:0] lo;
    logic [7:0] hi;
    nb = stored_bytes();
    if (restart) begin
      want_header = 1'b1;
      literal_left = 8'd0;
      run_left = 8'd0;
      byte_pos = 2'd0;
      gather = 32'd0;
    end
    // A header byte only loads the packet counters.
    if (cfg_comp && want_header) begin
      if (b >= trpd_pkg::RUN_FLAG) begin
        run_left = b - 8'd127;
        literal_left = 8'd0;
      end else begin
        literal_left = b + 8'd1;
        run_left = 8'd0;
      end
      want_header = 1'b0;
      byte_pos = 2'd0;
      gather = 32'd0;
      return;
    end
    gather = gather | (32'(b) << (8 * byte_pos));
    if (byte_pos + 1 < nb) begin
      byte_pos = byte_pos + 2'd1;
      return;
    end
    // Raw mode leaves the packet counters alone, so a later return to
    // compressed mode picks the packet up where it stood.
    px.count = 8'd1;
    if (cfg_comp) begin
      if (run_left != 8'd0) begin
        px.count = run_left;
        run_left = 8'd0;
        want_header = 1'b1;
      end else begin
        if (literal_left != 8'd0) literal_left = literal_left - 8'd1;
        if (literal_left == 8'd0) want_header = 1'b1;
      end
    end
    raw = gather;
    lo = raw[7:0];
    hi = raw[15:8];
    if (cfg_mode == trpd_pkg::CONV_EXPAND) begin
      // 5-5-5 from the two low bytes: red on top, blue at the bottom.
      px.value = {(cfg_alpha && hi[7]) ? 8'hff : 8'h00,
                  fill_low({lo[4:0], 3'b000}),
                  fill_low({hi[1:0], lo[7:5], 3'b000}),
                  fill_low({hi[6:2], 3'b000})};
      px.width = cfg_alpha ? 3'd4 : 3'd3;
    end else begin
      // Swapping needs at least three stored bytes; mode 3 passes through.
      if (cfg_mode == trpd_pkg::CONV_SWAP && nb >= 3) begin
        raw = {raw[31:24], raw[7:0], raw[15:8], raw[23:16]};
      end
      px.value = raw;
      px.width = nb[2:0];
    end
    pixel_due_q.push_back(px);
    byte_pos = 2'd0;
    gather = 32'd0;
  endfunction

  // Driver: a word stays on the port until it is taken. A new word, or a gap,
  // is chosen only when the port is free or the current word moves.
  always @(posedge clk_i) begin : drive_p
    payload_t w;
    logic gap;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) decode_byte(data_byte_i, restart_i);
      if (!in_valid_i || !in_stall_o) begin
        gap = (idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 82) ||
              (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 6);
        if (payload_q.size() != 0 && !gap) begin
          w = payload_q.pop_front();
          in_valid_i <= 1'b1;
          data_byte_i <= w.data;
          restart_i <= w.restart;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every pixel word that moves is checked against the oldest
  // prediction, then the stall for the next cycle is drawn.
  always @(posedge clk_i) begin : check_p
    pixel_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pixel_due_q.size() == 0) begin
          flag_error($sformatf("unexpected pixel word value %h width %0d run %0d",
                               pixel_value_o, pixel_width_o, run_length_o));
        end else begin
          want = pixel_due_q.pop_front();
          if (pixel_value_o !== want.value || pixel_width_o !== want.width ||
              run_length_o !== want.count) begin
            flag_error($sformatf({"pixel mismatch: value %h/%h width %0d/%0d run %0d/%0d",
                                  " (expected/actual)"},
                                 want.value, pixel_value_o, want.width, pixel_width_o,
                                 want.count, run_length_o));
          end
        end
      end
      out_stall_i <= (idle_mode == IDLE_RECEIVER && $urandom_range(0, 99) < 82) ||
                     (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 6);
    end
  end

  // Watchdog: a hung channel or a missing pixel word ends the run here.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin : watchdog_p
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Returns once every queued byte has been taken and every pixel word owed
  // has come out. Checked on the falling edge, away from the driving edge.
  task automatic wait_drained();
    @(negedge clk_i);
    while (payload_q.size() != 0 || in_valid_i || pixel_due_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      trpd_pkg::REG_COMPRESSED:   cfg_comp = val[0];
      trpd_pkg::REG_PIXEL_BYTES:  cfg_nbytes = val;
      trpd_pkg::REG_CONVERT_MODE: cfg_mode = val[1:0];
      trpd_pkg::REG_ALPHA_ENABLE: cfg_alpha = val[0];
      default: ;
    endcase
  endtask

  // Registers change only while the block idles. A last header or partial
  // pixel byte gives no output word, so the task also waits after the drain
  // to cover the output register.
  task automatic set_config(input setting_t s);
    wait_drained();
    repeat (3) @(posedge clk_i);
    write_reg(trpd_pkg::REG_COMPRESSED, {2'b00, s.comp});
    write_reg(trpd_pkg::REG_PIXEL_BYTES, s.nbytes);
    write_reg(trpd_pkg::REG_CONVERT_MODE, {1'b0, s.mode});
    write_reg(trpd_pkg::REG_ALPHA_ENABLE, {2'b00, s.alpha});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random stream for the current setting. In compressed mode most of it is
  // well-formed packets with random contents; the rest is cut-off packets
  // followed by a restart, and loose bytes with random restart flags.
  task automatic fill_stream(input int unsigned n, input logic lead_restart);
    int unsigned stop;
    int unsigned nb;
    int unsigned len;
    int unsigned pick;
    logic [7:0] hdr;
    logic rs;
    logic rs_next;
    stop = pushed + n;
    nb = stored_bytes();
    rs = lead_restart;
    while (pushed < stop) begin
      rs_next = 1'b0;
      if (!cfg_comp) begin
        push_byte(8'($urandom_range(0, 255)), rs || $urandom_range(0, 49) == 0);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 93) begin
          if (pick < 45) begin
            hdr = 8'($urandom_range(128, 255));
            len = nb;
          end else if (pick < 85) begin
            // Long literal packets are kept rare to bound the stream length.
            hdr = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(8, 127))
                                                : 8'($urandom_range(0, 7));
            len = (hdr + 1) * nb;
          end else begin
            hdr = 8'($urandom_range(0, 255));
            len = $urandom_range(0, 2 * nb);
            rs_next = 1'b1;
          end
          push_byte(hdr, rs);
          repeat (len) push_byte(8'($urandom_range(0, 255)), 1'b0);
        end else begin
          repeat ($urandom_range(1, 6))
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
      end
      rs = rs_next;
    end
  endtask

  // Settings of the random phases: both modes, every pixel size including
  // the saturated register values, every convert mode, alpha on and off.
  setting_t plan[10] = '{
    '{1'b1, 3'd3, trpd_pkg::CONV_SWAP,   1'b0},
    '{1'b1, 3'd1, trpd_pkg::CONV_EXPAND, 1'b1},
    '{1'b1, 3'd4, trpd_pkg::CONV_PASS,   1'b0},
    '{1'b0, 3'd2, trpd_pkg::CONV_EXPAND, 1'b1},
    '{1'b1, 3'd2, trpd_pkg::CONV_EXPAND, 1'b0},
    '{1'b0, 3'd4, trpd_pkg::CONV_SWAP,   1'b1},
    '{1'b1, 3'd0, CONV_SPARE,            1'b0},
    '{1'b1, 3'd7, trpd_pkg::CONV_SWAP,   1'b0},
    '{1'b0, 3'd1, trpd_pkg::CONV_SWAP,   1'b0},
    '{1'b1, 3'd3, trpd_pkg::CONV_EXPAND, 1'b1}
  };

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting: raw, three bytes, passthrough. Extreme bytes, then a
    // pixel that starts with a restart.
    push_byte(8'hff, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h01, 1'b1);
    push_byte(8'h02, 1'b0);
    push_byte(8'h03, 1'b0);

    // Packets with 16-bit pixels expanded to 8-bit channels plus alpha: the
    // longest run, the shortest run, a one-pixel literal, and a 128-pixel
    // literal that is left open.
    set_config('{1'b1, 3'd2, trpd_pkg::CONV_EXPAND, 1'b1});
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h1f, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7f, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);

    // Raw mode in the middle of that packet: a zero pixel size with the spare
    // convert mode, then a swap with too few bytes to apply.
    set_config('{1'b0, 3'd0, CONV_SPARE, 1'b0});
    push_byte(8'h00, 1'b0);
    set_config('{1'b0, 3'd1, trpd_pkg::CONV_SWAP, 1'b0});
    push_byte(8'hff, 1'b0);

    // Back to packets with an oversized pixel size: the open literal packet
    // resumes and its next pixel is byte-swapped.
    set_config('{1'b1, 3'd5, trpd_pkg::CONV_SWAP, 1'b0});
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b0);
    push_byte(8'h33, 1'b0);
    push_byte(8'h44, 1'b0);

    // Random phases. Idling rotates through none, sender, receiver and both.
    // On every other phase the sender holds off halfway until all pixel
    // words owed have come out.
    foreach (plan[p]) begin
      set_config(plan[p]);
      idle_mode = idle_e'(p % 4);
      fill_stream(PHASE_ITEMS / 2, $urandom_range(0, 2) != 0);
      if (p % 2 == 0) wait_drained();
      fill_stream(PHASE_ITEMS / 2, 1'b0);
    end

    // A missing pixel word never drains and ends in the watchdog instead.
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* tga_rle_pixel_decoder.f */
+incdir+hw/rtl
hw/rtl/trpd_pkg.sv
hw/rtl/trpd_convert.sv
hw/rtl/tga_rle_pixel_decoder.sv
hw/rtl/trpd_checker.sv
sim/tga_rle_pixel_decoder_tb.sv
